// File: design/rans_esc_pkg.sv
// Shared constants, codes and types of the rANS encoder with escape coding.
`default_nettype none
package rans_esc_pkg;

    // Fixed field and state widths
    localparam int STATE_W   = 64;
    localparam int WORD_W    = 32;
    localparam int OP_W      = 2;
    localparam int SYM_W     = 16;
    localparam int CFG_IDX_W = 1;

    // Raw coding of an escaped sample: start = pattern * 256, frequency 256
    localparam int RAW_FREQ  = 256;
    localparam int RAW_SHIFT = 8;

    // Quotient bits produced per divider cycle
    localparam int DIV_DIGIT = 2;

    // State after reset and after a flush
    localparam logic [STATE_W-1:0] STATE_LOW = 64'h0000_0000_8000_0000;

    // Operation codes
    localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
    localparam logic [OP_W-1:0] OP_ENCODE = 2'd1;
    localparam logic [OP_W-1:0] OP_FLUSH  = 2'd2;
    localparam logic [OP_W-1:0] OP_NOP    = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ESC_START = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ESC_FREQ  = 1'd1;

    // One result item
    typedef struct packed {
        logic              last;
        logic [WORD_W-1:0] word;
    } t_out_item;

endpackage
`default_nettype wire

// File: design/rans_encoder_with_escape.sv
// Top level of the static-model rANS encoder with escape coding.
//
//  channel  direction  handshake                 payload
//  input    in         i_valid / o_stall         i_op, i_symbol, i_entry_start, i_entry_freq
//  result   out        o_valid / i_stall         o_word, o_last
//  config   in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// A load is taken at idle; a flush pushes the low, then the high state word. A coded
// sample passes read, renorm, divide and finish; an escaped sample passes renorm and
// divide twice. Pushes wait on a full queue; the divider makes 2 quotient bits a step.
// Synchronous active-low reset sets the state to 2^31; the tables keep their
// contents and must be loaded before use. Up to two result words queue up
// while the next item is taken; o_valid never looks at i_stall.
`default_nettype none
module rans_encoder_with_escape
    import rans_esc_pkg::*;
#(
    parameter int PROB_BITS   = 24,
    parameter int SYMBOL_BITS = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // input items
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic [OP_W-1:0]       i_op,
    input  wire logic [SYM_W-1:0]      i_symbol,
    input  wire logic [PROB_BITS-1:0]  i_entry_start,
    input  wire logic [PROB_BITS:0]    i_entry_freq,
    // result items
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic      [WORD_W-1:0]     o_word,
    output logic                       o_last,
    // configuration writes
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [PROB_BITS:0]    i_cfg_data
);

    localparam int SW     = PROB_BITS;
    localparam int FW     = PROB_BITS + 1;
    localparam int RN_LSB = STATE_W - 1 - PROB_BITS;
    localparam int ADD_W  = (SW > SYMBOL_BITS + RAW_SHIFT) ? SW : SYMBOL_BITS + RAW_SHIFT;

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_READ     = 7'b0000010,
        S_RENORM   = 7'b0000100,
        S_DIV      = 7'b0001000,
        S_FINISH   = 7'b0010000,
        S_FLUSH_LO = 7'b0100000,
        S_FLUSH_HI = 7'b1000000
    } t_state;

    t_state                 r_state, n_state;
    logic [STATE_W-1:0]     r_x, n_x;
    logic [FW-1:0]          r_f, n_f;
    logic [ADD_W-1:0]       r_start, n_start;
    logic                   r_esc, n_esc;
    logic [WORD_W-1:0]      r_pend, n_pend;
    logic                   r_pend_vld, n_pend_vld;
    logic [SYMBOL_BITS-1:0] r_sym, n_sym;
    logic [SW-1:0]          r_esc_start;
    logic [FW-1:0]          r_esc_freq;

    logic                   in_acc;
    logic                   ram_we;
    logic [SW+FW-1:0]       ram_rdata;
    logic [SW-1:0]          rd_start;
    logic [FW-1:0]          rd_freq;
    logic                   emit;
    logic                   div_start;
    logic [STATE_W-1:0]     div_dvd;
    logic                   div_done;
    logic [STATE_W-1:0]     div_quot;
    logic [FW-1:0]          div_rem;
    logic                   core_push;
    t_out_item              push_item;
    t_out_item              out_item;
    logic                   fifo_full;

    assign o_stall     = (r_state != S_IDLE);
    assign in_acc      = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;
    assign ram_we      = in_acc && (i_op == OP_LOAD);
    assign rd_start    = ram_rdata[SW+FW-1:FW];
    assign rd_freq     = ram_rdata[FW-1:0];
    assign emit        = (r_x[STATE_W-1:RN_LSB] >= r_f);

    // Start and frequency tables, one entry per symbol
    rans_esc_ram #(
        .WIDTH (SW + FW),
        .DEPTH (2 ** SYMBOL_BITS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (i_symbol[SYMBOL_BITS-1:0]),
        .i_wdata ({i_entry_start, i_entry_freq}),
        .o_rdata (ram_rdata)
    );

    // State divided by frequency
    rans_esc_div #(
        .DIV_W (FW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (r_f),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    // Result queue
    rans_esc_ofifo u_ofifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (core_push),
        .i_item  (push_item),
        .o_full  (fifo_full),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_item  (out_item)
    );

    assign o_word = out_item.word;
    assign o_last = out_item.last;

    // Sequence load, encode and flush items
    always_comb begin
        n_state    = r_state;
        n_x        = r_x;
        n_f        = r_f;
        n_start    = r_start;
        n_esc      = r_esc;
        n_pend     = r_pend;
        n_pend_vld = r_pend_vld;
        n_sym      = r_sym;
        core_push  = 1'b0;
        push_item  = '{last: 1'b0, word: r_pend};
        div_start  = 1'b0;
        div_dvd    = r_x;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (i_op)
                        OP_ENCODE: begin
                            n_sym   = i_symbol[SYMBOL_BITS-1:0];
                            n_state = S_READ;
                        end
                        OP_FLUSH: begin
                            n_state = S_FLUSH_LO;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_READ: begin
                // pick table symbol or raw pattern
                if (rd_freq != '0) begin
                    n_f     = rd_freq;
                    n_start = ADD_W'(rd_start);
                    n_esc   = 1'b0;
                end else begin
                    n_f     = FW'(RAW_FREQ);
                    n_start = ADD_W'({r_sym, {RAW_SHIFT{1'b0}}});
                    n_esc   = 1'b1;
                end
                n_state = S_RENORM;
            end
            S_RENORM: begin
                // hold while an older pending word has no room
                if (!(emit && r_pend_vld && fifo_full)) begin
                    if (emit) begin
                        core_push  = r_pend_vld;
                        n_pend     = r_x[WORD_W-1:0];
                        n_pend_vld = 1'b1;
                        div_dvd    = {{WORD_W{1'b0}}, r_x[STATE_W-1:WORD_W]};
                    end
                    n_x       = div_dvd;
                    div_start = 1'b1;
                    n_state   = S_DIV;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_x = {div_quot[STATE_W-1-PROB_BITS:0], {PROB_BITS{1'b0}}}
                        + STATE_W'(div_rem) + STATE_W'(r_start);
                    if (r_esc) begin
                        n_f     = (r_esc_freq == '0) ? FW'(1) : r_esc_freq;
                        n_start = ADD_W'(r_esc_start);
                        n_esc   = 1'b0;
                        n_state = S_RENORM;
                    end else begin
                        n_state = S_FINISH;
                    end
                end
            end
            S_FINISH: begin
                // release the final word of the item
                if (!r_pend_vld) begin
                    n_state = S_IDLE;
                end else if (!fifo_full) begin
                    core_push  = 1'b1;
                    push_item  = '{last: 1'b1, word: r_pend};
                    n_pend_vld = 1'b0;
                    n_state    = S_IDLE;
                end
            end
            S_FLUSH_LO: begin
                if (!fifo_full) begin
                    core_push = 1'b1;
                    push_item = '{last: 1'b0, word: r_x[WORD_W-1:0]};
                    n_state   = S_FLUSH_HI;
                end
            end
            S_FLUSH_HI: begin
                if (!fifo_full) begin
                    core_push = 1'b1;
                    push_item = '{last: 1'b1, word: r_x[STATE_W-1:WORD_W]};
                    n_x       = STATE_LOW;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state and coder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_x        <= STATE_LOW;
            r_esc      <= 1'b0;
            r_pend_vld <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_x        <= n_x;
            r_esc      <= n_esc;
            r_pend_vld <= n_pend_vld;
        end
    end

    // Payload of the symbol at work
    always_ff @(posedge i_clk) begin
        r_f     <= n_f;
        r_start <= n_start;
        r_pend  <= n_pend;
        r_sym   <= n_sym;
    end

    // Take configuration transfers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc_start <= '0;
            r_esc_freq  <= FW'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_ESC_START: r_esc_start <= i_cfg_data[SW-1:0];
                CFG_ESC_FREQ:  r_esc_freq  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Checks
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        core_push |-> !fifo_full)
        else $error("word pushed into a full output queue");

    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV))
        else $error("divider finished outside the divide step");

    a_flush_rearm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FLUSH_HI && core_push) |=> (r_x == STATE_LOW))
        else $error("state not restored after flush");

    a_pend_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_vld |-> (r_state != S_IDLE))
        else $error("pending word left behind at idle");

endmodule
`default_nettype wire

// File: design/rans_esc_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none
module rans_esc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write on request, read every cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule
`default_nettype wire

// File: design/rans_esc_div.sv
// Digit-serial restoring divider: 64-bit dividend by a narrow divisor.
`default_nettype none
module rans_esc_div
    import rans_esc_pkg::*;
#(
    parameter int DIV_W = 25
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [STATE_W-1:0] i_dividend,
    input  wire logic [DIV_W-1:0]   i_divisor,
    output logic                    o_done,
    output logic      [STATE_W-1:0] o_quot,
    output logic      [DIV_W-1:0]   o_rem
);

    localparam int STEPS = STATE_W / DIV_DIGIT;
    localparam int CNT_W = $clog2(STEPS);

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [STATE_W-1:0] r_q;
    logic [DIV_W-1:0]   r_rem;
    logic [DIV_W-1:0]   r_d;
    logic [STATE_W-1:0] n_q;
    logic [DIV_W-1:0]   n_rem;

    // Shift in dividend bits, compare and subtract, one digit per cycle
    always_comb begin
        logic [DIV_W:0]     trial;
        logic [STATE_W-1:0] q_v;
        logic [DIV_W-1:0]   rem_v;
        q_v   = r_q;
        rem_v = r_rem;
        trial = '0;
        for (int k = 0; k < DIV_DIGIT; k++) begin
            trial = {rem_v, q_v[STATE_W-1]};
            q_v   = {q_v[STATE_W-2:0], 1'b0};
            if (trial >= {1'b0, r_d}) begin
                trial  = trial - {1'b0, r_d};
                q_v[0] = 1'b1;
            end
            rem_v = trial[DIV_W-1:0];
        end
        n_q   = q_v;
        n_rem = rem_v;
    end

    // Sequence the steps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Hold dividend, quotient and remainder
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_d   <= i_divisor;
        end else if (r_busy) begin
            r_q   <= n_q;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_rem;

endmodule
`default_nettype wire

// File: design/rans_esc_ofifo.sv
// Two-entry output queue between the coder and the result channel.
`default_nettype none
module rans_esc_ofifo
    import rans_esc_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_push,
    input  wire t_out_item i_item,
    output logic           o_full,
    output logic           o_valid,
    input  wire logic      i_stall,
    output t_out_item      o_item
);

    t_out_item  r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       pop;

    assign pop     = o_valid && !i_stall;
    assign o_valid = (r_cnt != 2'd0);
    assign o_full  = (r_cnt == 2'd2);
    assign o_item  = r_mem[r_rp];

    // Advance pointers and count on each transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (pop) begin
                r_rp <= !r_rp;
            end
            if (i_push && !pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (pop && !i_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    // Store the pushed item
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule
`default_nettype wire
